// ===== sv/brm_pkg.sv =====
// Shared constants, types and Booth recoding for the radix-4 Booth multiplier.
package brm_pkg;

    localparam int WIDTH  = 32;                 // operand width used by the datapath
    localparam int IN_W   = 32;                 // operand field width on the port
    localparam int OUT_W  = 64;                 // product field width on the port
    localparam int NPP    = (WIDTH + 1) / 2;    // Booth digits / partial products
    localparam int LVLS   = $clog2(NPP);        // adder tree levels
    localparam int NPP_P2 = 1 << LVLS;          // tree leaves, padded with zeros
    localparam int LAT    = LVLS + 1;           // register stages, input to output

    typedef logic [OUT_W-1:0] t_prod;

    typedef enum logic [2:0] {
        DIG_ZERO,
        DIG_POS1,
        DIG_POS2,
        DIG_NEG1,
        DIG_NEG2
    } t_digit;

    // triple = {b[2i+1], b[2i], b[2i-1]}
    function automatic t_digit brm_recode(input logic [2:0] trip);
        t_digit dig;
        case (trip)
            3'b001: dig = DIG_POS1;
            3'b010: dig = DIG_POS1;
            3'b011: dig = DIG_POS2;
            3'b100: dig = DIG_NEG2;
            3'b101: dig = DIG_NEG1;
            3'b110: dig = DIG_NEG1;
            default: dig = DIG_ZERO;
        endcase
        return dig;
    endfunction

endpackage

// ===== sv/brm_pp_gen.sv =====
// First pipeline stage: Booth recoding and partial product selection.
module brm_pp_gen (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [brm_pkg::IN_W-1:0]  i_multiplicand,
    input  logic [brm_pkg::IN_W-1:0]  i_multiplier,
    output logic                      o_valid,
    input  logic                      i_ready,
    output brm_pkg::t_prod            o_pp [brm_pkg::NPP_P2]
);
    import brm_pkg::*;

    logic             r_vld;
    t_prod            r_pp [NPP_P2];
    t_prod            n_pp [NPP_P2];
    logic [WIDTH+1:0] q_ext;
    t_prod            m1;
    t_prod            m2;

    // multiplier with implied zero below bit 0 and one extra sign bit
    assign q_ext = {i_multiplier[WIDTH-1], i_multiplier[WIDTH-1:0], 1'b0};
    assign m1    = {{(OUT_W-WIDTH){i_multiplicand[WIDTH-1]}}, i_multiplicand[WIDTH-1:0]};
    assign m2    = {m1[OUT_W-2:0], 1'b0};

    always_comb begin
        t_prod sel;
        for (int k = 0; k < NPP_P2; k++) begin
            sel = '0;
            if (k < NPP) begin
                case (brm_recode(q_ext[2*k +: 3]))
                    DIG_POS1: sel = m1;
                    DIG_POS2: sel = m2;
                    DIG_NEG1: sel = t_prod'(0) - m1;
                    DIG_NEG2: sel = t_prod'(0) - m2;
                    default:  sel = '0;
                endcase
            end
            n_pp[k] = sel << (2 * k);
        end
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_pp    = r_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pp <= n_pp;
        end
    end

endmodule

// ===== sv/brm_add_tree.sv =====
// Registered binary adder tree: one level of pairwise adds per stage.
module brm_add_tree (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  brm_pkg::t_prod i_pp [brm_pkg::NPP_P2],
    output logic           o_valid,
    input  logic           i_ready,
    output brm_pkg::t_prod o_sum
);
    import brm_pkg::*;

    // nodes of level l start at NPP_P2 - (NPP_P2 >> l); the root is last
    t_prod           r_node [NPP_P2-1];
    logic [LVLS-1:0] r_vld;
    logic [LVLS-1:0] stg_rdy;
    logic [LVLS-1:0] stg_vin;

    always_comb begin
        stg_vin[0]      = i_valid;
        stg_rdy[LVLS-1] = !r_vld[LVLS-1] || i_ready;
        for (int l = 1; l < LVLS; l++) begin
            stg_vin[l] = r_vld[l-1];
        end
        for (int l = LVLS - 2; l >= 0; l--) begin
            stg_rdy[l] = !r_vld[l] || stg_rdy[l+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int l = 0; l < LVLS; l++) begin
                if (stg_rdy[l]) begin
                    r_vld[l] <= stg_vin[l];
                end
            end
        end
    end

    for (genvar l = 0; l < LVLS; l++) begin : g_lvl
        localparam int BASE = NPP_P2 - (NPP_P2 >> l);
        localparam int CNT  = NPP_P2 >> (l + 1);
        for (genvar j = 0; j < CNT; j++) begin : g_node
            t_prod opa;
            t_prod opb;
            if (l == 0) begin : g_leaf
                assign opa = i_pp[2*j];
                assign opb = i_pp[2*j+1];
            end else begin : g_inner
                localparam int PBASE = NPP_P2 - (NPP_P2 >> (l - 1));
                assign opa = r_node[PBASE+2*j];
                assign opb = r_node[PBASE+2*j+1];
            end
            always_ff @(posedge i_clk) begin
                if (stg_rdy[l]) begin
                    r_node[BASE+j] <= opa + opb;
                end
            end
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_vld[LVLS-1];
    assign o_sum   = r_node[NPP_P2-2];

endmodule

// ===== sv/booth_radix4_multiplier.sv =====
// Top level of the pipelined radix-4 Booth multiplier.
//
// Usage:
//   Slave stream carries one operand pair per transfer:
//     s_axis_tdata[31:0]  multiplicand (signed)
//     s_axis_tdata[63:32] multiplier   (signed)
//   Master stream carries the signed 64-bit product per transfer.
// Pipeline: one stage of Booth recoding and partial product selection,
//   then four adder tree levels reducing 16 partial products pairwise,
//   each level one 64-bit add deep.
// Throughput: one transfer per cycle while the output is taken; each stage holds
//   its own valid bit and advances when it is empty or the stage after it advances.
// Stall: when the master side is not ready the last stage holds its
//   product; earlier stages keep moving into empty slots, so input stays
//   ready until all five stages are full. Nothing is dropped or repeated.
// Reset: i_rst_n (synchronous, active low) clears every valid bit; the
//   datapath registers are not reset.
module booth_radix4_multiplier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] multiplicand, [63:32] multiplier
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [63:0] product
);
    import brm_pkg::*;

    logic  pp_valid;
    logic  pp_ready;
    t_prod pp [NPP_P2];
    t_prod sum;

    // recode + select, one register stage
    brm_pp_gen u_pp_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_multiplicand (i_s_axis_tdata[IN_W-1:0]),
        .i_multiplier   (i_s_axis_tdata[2*IN_W-1:IN_W]),
        .o_valid        (pp_valid),
        .i_ready        (pp_ready),
        .o_pp           (pp)
    );

    // pairwise reduction, one register stage per tree level
    brm_add_tree u_add_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pp_valid),
        .o_ready (pp_ready),
        .i_pp    (pp),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sum   (sum)
    );

    assign o_m_axis_tdata = sum;

endmodule

// ===== sv/brm_checker.sv =====
// Port-level checks for the Booth multiplier, bound to the top level.
module brm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);
    import brm_pkg::*;

    localparam int CNT_W = $clog2(LAT + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    // items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (out_xfer && !in_xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled product changed or vanished");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_m_axis_tvalid)
        else $error("product shown with nothing in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(LAT))
        else $error("more items in flight than pipeline stages");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> o_s_axis_tready)
        else $error("empty pipeline refuses input");

endmodule

bind booth_radix4_multiplier brm_checker u_brm_checker (.*);

// ===== bench/tb.sv =====
// Self-checking stream testbench for the radix-4 Booth multiplier.
`timescale 1ns / 1ps

module tb;
    import brm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int N_RANDOM       = 2000;
    localparam int MAX_REPORTS    = 10;

    // Holds the products still owed by the block, predicted in transfer order.
    class product_scoreboard;
        t_prod pending_q[$];
        int    n_noted;
        int    n_checked;
        int    n_mismatch;
        int    n_unexpected;

        function new();
            n_noted      = 0;
            n_checked    = 0;
            n_mismatch   = 0;
            n_unexpected = 0;
        endfunction

        // Booth radix-4: triples {b[2i+1], b[2i], b[2i-1]} with an implied zero below bit 0.
        function t_prod booth_product(logic [IN_W-1:0] mc, logic [IN_W-1:0] mp);
            logic signed [WIDTH-1:0] m_w;
            logic signed [WIDTH-1:0] q_w;
            logic signed [OUT_W-1:0] m_ext;
            logic signed [OUT_W-1:0] q_ext;
            logic signed [OUT_W-1:0] part;
            logic signed [OUT_W-1:0] acc;
            logic [2*NPP:0]          scan;
            logic [2:0]              trip;
            t_digit                  dig;
            m_w   = mc[WIDTH-1:0];
            q_w   = mp[WIDTH-1:0];
            m_ext = m_w;                          // sign extension through signed assign
            q_ext = q_w;
            scan  = {q_ext[2*NPP-1:0], 1'b0};     // odd WIDTH picks up the sign bit twice
            acc   = '0;
            for (int i = 0; i < NPP; i++) begin
                trip = scan[2*i +: 3];
                case (trip)
                    3'b001, 3'b010: dig = DIG_POS1;
                    3'b011:         dig = DIG_POS2;
                    3'b100:         dig = DIG_NEG2;
                    3'b101, 3'b110: dig = DIG_NEG1;
                    default:        dig = DIG_ZERO;
                endcase
                case (dig)
                    DIG_POS1: part = m_ext;
                    DIG_POS2: part = m_ext <<< 1;
                    DIG_NEG1: part = -m_ext;
                    DIG_NEG2: part = -(m_ext <<< 1);
                    default:  part = '0;
                endcase
                acc = acc + (part <<< (2*i));
            end
            return acc;
        endfunction

        function void note_operands(logic [IN_W-1:0] mc, logic [IN_W-1:0] mp);
            pending_q.push_back(booth_product(mc, mp));
            n_noted++;
        endfunction

        function void check_product(t_prod got);
            t_prod want;
            if (pending_q.size() == 0) begin
                n_unexpected++;
                if (n_unexpected + n_mismatch <= MAX_REPORTS)
                    $display("ERROR: product %h arrived with nothing outstanding", got);
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got !== want) begin
                n_mismatch++;
                if (n_unexpected + n_mismatch <= MAX_REPORTS)
                    $display("ERROR: product #%0d expected %h got %h",
                             n_checked, want, got);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        function int failures();
            return n_mismatch + n_unexpected + pending_q.size();
        endfunction
    endclass

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero.
    // ---------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [63:0] s_data = '0;                 // [31:0] multiplicand, [63:32] multiplier
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [63:0] o_m_axis_tdata;              // [63:0] product

    booth_radix4_multiplier u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    product_scoreboard sb = new();

    int idle_cycles  = 0;
    int stall_cycles = 0;
    int burst_left   = 0;

    // ---------------------------------------------------------------
    // Transfer monitor and watchdog. Sampling right after the edge sees
    // the values that were present at the edge, since everything is
    // driven by nonblocking assignments. The input side is noted first;
    // a product is registered before the output, so same-edge order does not matter.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready)
                sb.note_operands(s_data[31:0], s_data[63:32]);
            if (o_m_axis_tvalid && m_ready)
                sb.check_product(o_m_axis_tdata);
            if (o_m_axis_tvalid && !m_ready)
                stall_cycles++;
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d products outstanding",
                         idle_cycles, sb.outstanding());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver backpressure: a mode picked whenever the 7-bit phase counter wraps,
    // among always-ready, coin flip, rare long stalls and alternating.
    // ---------------------------------------------------------------
    logic [6:0] rx_phase = '0;
    logic [1:0] rx_mode  = '0;
    int         rx_stall = 0;

    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 7'd1;
        if (rx_phase == 7'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: begin
                if (rx_stall != 0) begin
                    rx_stall <= rx_stall - 1;
                    m_ready  <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_stall <= $urandom_range(1, 24);
                    m_ready  <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            default: m_ready <= ~m_ready;
        endcase
    end

    // ---------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them. About
    // half of the bursts start back to back, giving stretches with no gaps.
    // ---------------------------------------------------------------
    task automatic send_pair(input logic [31:0] mc, input logic [31:0] mp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= {mp, mc};
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
    endtask

    // Operand mix: mostly full-range random, with extremes, small values and single set bits.
    function automatic logic [31:0] pick_operand();
        logic [31:0] edges[6];
        edges = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};
        case ($urandom_range(0, 9))
            0:       return edges[$urandom_range(0, 5)];
            1:       return 32'($signed($urandom_range(0, 15)) - 8);
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus: directed corner pairs, then random pairs, then drain.
    // ---------------------------------------------------------------
    logic [31:0] dir_mc[$];
    logic [31:0] dir_mp[$];

    initial begin
        // Extremes of both operands, most negative products included.
        dir_mc = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'h8000_0000, 32'h1234_5678,
                   // multiplier patterns that walk every Booth triple
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0003,
                   32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFE};
        dir_mp = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h0000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC,
                   32'h6666_6666, 32'h9999_9999, 32'h0F0F_0F0F, 32'hF0F0_F0F0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_mc[k])
            send_pair(dir_mc[k], dir_mp[k]);
        repeat (N_RANDOM)
            send_pair(pick_operand(), pick_operand());
        s_valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray output.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);

        $display("Run covered %0d operand pairs (%0d directed), %0d products checked",
                 sb.n_noted, dir_mc.size(), sb.n_checked);
        $display("Output stalled for %0d cycles; %0d mismatches, %0d unexpected products",
                 stall_cycles, sb.n_mismatch, sb.n_unexpected);
        if (sb.failures() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
